// File: sv/qe_pkg.sv
// ----------------------------------------------------------------------------
// qe_pkg
// shared constants and the cordic arctangent table for the euler angle block
// ----------------------------------------------------------------------------
package qe_pkg;

	localparam int ANG_W     = 30;	// angle in degrees x 2^20
	localparam int ANG_SHIFT = 20;
	localparam int ROLL_W    = 15;
	localparam int PITCH_W   = 14;
	localparam int YAW_W     = 15;
	localparam int SQ_W      = 62;
	localparam int SQ_CELLS  = 31;
	localparam int OUT_TDATA_W = 48;

	localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(90) <<< ANG_SHIFT;

	// atan(2^-i) in degrees x 2^20
	function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
		logic signed [ANG_W-1:0] v;
		case (i)
			0: v = ANG_W'(47185920);
			1: v = ANG_W'(27855475);
			2: v = ANG_W'(14718068);
			3: v = ANG_W'(7471121);
			4: v = ANG_W'(3750058);
			5: v = ANG_W'(1876857);
			6: v = ANG_W'(938658);
			7: v = ANG_W'(469357);
			8: v = ANG_W'(234682);
			9: v = ANG_W'(117342);
			10: v = ANG_W'(58671);
			11: v = ANG_W'(29335);
			12: v = ANG_W'(14668);
			13: v = ANG_W'(7334);
			14: v = ANG_W'(3667);
			15: v = ANG_W'(1833);
			16: v = ANG_W'(917);
			17: v = ANG_W'(458);
			18: v = ANG_W'(229);
			19: v = ANG_W'(115);
			20: v = ANG_W'(57);
			21: v = ANG_W'(29);
			22: v = ANG_W'(14);
			23: v = ANG_W'(7);
			24: v = ANG_W'(4);
			25: v = ANG_W'(2);
			26: v = ANG_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: sv/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// quaternion (q2.14) to roll, pitch and yaw in degrees x 64, z-y-x order
// ----------------------------------------------------------------------------
// usage
//   a request on the s_ group carries one quaternion w, x, y, z; the block
//   answers with one request on the m_ group holding roll, pitch and yaw.
//   roll and yaw come from a full-quadrant cordic atan2, pitch from the
//   atan2 of the clamped pitch term and its cosine.
//   data passes three product and term stages, 31 square root cells,
//   the quadrant fold, the cordic cells and the rounding stage.
//   one quaternion is taken every cycle while m_tready stays high; the rate
//   is set by the single-step cells of the square root and cordic chains.
//   when the receiver stalls with a result waiting, the whole pipeline
//   holds and s_tready drops in the same cycle.
//   reset clears all valid flags; no result is pending after reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import qe_pkg::*; #(
	parameter int QUAT_BITS       = 16,
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// quat_w, quat_x, quat_y, quat_z
	input  logic [((4*QUAT_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// roll_angle, pitch_angle, yaw_angle
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int WB   = (QUAT_BITS > 24) ? 24 : QUAT_BITS;
	localparam int QF   = WB - 2;
	localparam int PW   = 2 * WB;
	localparam int TW   = 2 * WB + 3;
	localparam int CW   = (2 * WB + 5 > 34) ? 2 * WB + 5 : 34;
	localparam int SH   = 2 * QF - 30;
	localparam int LAT  = 3 + SQ_CELLS + CORDIC_STAGES + 2;
	localparam logic signed [TW-1:0] ONE = TW'(1) <<< (2 * QF);

	logic                 en;
	logic [LAT-1:0]       vld_q;
	logic signed [WB-1:0] q [4];

	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic signed [TW-1:0] t0, t1, t2, t3, t4, t2c;
	logic signed [63:0]   pw;
	logic signed [TW-1:0] t0_s2, t1_s2, t3_s2, t4_s2;
	logic signed [31:0]   p_s2;
	logic signed [TW-1:0] t0_s3, t1_s3, t3_s3, t4_s3;
	logic signed [31:0]   p_s3;
	logic signed [63:0]   pp_s3;

	logic [SQ_W-1:0]      sv [SQ_CELLS+1];
	logic [SQ_W-1:0]      sr [SQ_CELLS+1];
	logic signed [TW-1:0] d0_q [SQ_CELLS];
	logic signed [TW-1:0] d1_q [SQ_CELLS];
	logic signed [TW-1:0] d3_q [SQ_CELLS];
	logic signed [TW-1:0] d4_q [SQ_CELLS];
	logic signed [31:0]   dp_q [SQ_CELLS];

	logic [ROLL_W-1:0]  roll;
	logic [PITCH_W-1:0] pitch;
	logic [YAW_W-1:0]   yaw;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = {4'b0, yaw, pitch, roll};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// floor inputs to the working width
	for (genvar k = 0; k < 4; k++) begin : g_load
		logic signed [QUAT_BITS-1:0] raw;
		assign raw  = s_tdata[k*QUAT_BITS +: QUAT_BITS];
		assign q[k] = WB'(raw >>> (QUAT_BITS - WB));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= q[0] * q[1];
			yz_s1 <= q[2] * q[3];
			xx_s1 <= q[1] * q[1];
			yy_s1 <= q[2] * q[2];
			wy_s1 <= q[0] * q[2];
			zx_s1 <= q[3] * q[1];
			wz_s1 <= q[0] * q[3];
			xy_s1 <= q[1] * q[2];
			zz_s1 <= q[3] * q[3];
		end
	end

	assign t0 = (TW'(wx_s1) + TW'(yz_s1)) <<< 1;
	assign t1 = ONE - ((TW'(xx_s1) + TW'(yy_s1)) <<< 1);
	assign t2 = (TW'(wy_s1) - TW'(zx_s1)) <<< 1;
	assign t3 = (TW'(wz_s1) + TW'(xy_s1)) <<< 1;
	assign t4 = ONE - ((TW'(yy_s1) + TW'(zz_s1)) <<< 1);
	assign t2c = (t2 > ONE) ? ONE : ((t2 < -ONE) ? -ONE : t2);

	if (SH >= 0) begin : g_down
		assign pw = 64'(t2c) >>> SH;
	end else begin : g_up
		assign pw = 64'(t2c) <<< (-SH);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s2 <= t0;
			t1_s2 <= t1;
			t3_s2 <= t3;
			t4_s2 <= t4;
			p_s2  <= 32'(pw);
			t0_s3 <= t0_s2;
			t1_s3 <= t1_s2;
			t3_s3 <= t3_s2;
			t4_s3 <= t4_s2;
			p_s3  <= p_s2;
			pp_s3 <= p_s2 * p_s2;
		end
	end

	// cosine of pitch: floor(sqrt(2^60 - p^2))
	assign sv[0] = (SQ_W'(1) << 60) - SQ_W'(pp_s3);
	assign sr[0] = '0;

	for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
		qe_sqrt_cell #(.IDX(i)) u_sqrt (
			.clk   (clk),
			.en    (en),
			.v_in  (sv[i]),
			.res_in(sr[i]),
			.v_q   (sv[i+1]),
			.res_q (sr[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d0_q[0] <= t0_s3;
			d1_q[0] <= t1_s3;
			d3_q[0] <= t3_s3;
			d4_q[0] <= t4_s3;
			dp_q[0] <= p_s3;
			for (int i = 1; i < SQ_CELLS; i++) begin
				d0_q[i] <= d0_q[i-1];
				d1_q[i] <= d1_q[i-1];
				d3_q[i] <= d3_q[i-1];
				d4_q[i] <= d4_q[i-1];
				dp_q[i] <= dp_q[i-1];
			end
		end
	end

	qe_cordic_lane #(
		.CW(CW), .STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS),
		.OUT_W(ROLL_W), .LIM_DEG(180)
	) u_roll (
		.clk    (clk),
		.en     (en),
		.y_in   (CW'(d0_q[SQ_CELLS-1])),
		.x_in   (CW'(d1_q[SQ_CELLS-1])),
		.angle_q(roll)
	);

	qe_cordic_lane #(
		.CW(CW), .STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS),
		.OUT_W(PITCH_W), .LIM_DEG(90)
	) u_pitch (
		.clk    (clk),
		.en     (en),
		.y_in   (CW'(dp_q[SQ_CELLS-1])),
		.x_in   (CW'(signed'({1'b0, sr[SQ_CELLS][31:0]}))),
		.angle_q(pitch)
	);

	qe_cordic_lane #(
		.CW(CW), .STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS),
		.OUT_W(YAW_W), .LIM_DEG(180)
	) u_yaw (
		.clk    (clk),
		.en     (en),
		.y_in   (CW'(d3_q[SQ_CELLS-1])),
		.x_in   (CW'(d4_q[SQ_CELLS-1])),
		.angle_q(yaw)
	);

endmodule

// File: sv/qe_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qe_sqrt_cell
// one digit step of the pipelined integer square root
// ----------------------------------------------------------------------------
module qe_sqrt_cell import qe_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            en,
	input  logic [SQ_W-1:0] v_in,
	input  logic [SQ_W-1:0] res_in,
	output logic [SQ_W-1:0] v_q,
	output logic [SQ_W-1:0] res_q
);

	localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_CELLS - 1 - IDX));

	logic [SQ_W-1:0] sum;
	logic            ge;

	assign sum = res_in + BIT;
	assign ge  = v_in >= sum;

	always_ff @(posedge clk) begin
		if (en) begin
			v_q   <= ge ? v_in - sum : v_in;
			res_q <= ge ? (res_in >> 1) + BIT : res_in >> 1;
		end
	end

endmodule

// File: sv/qe_cordic_cell.sv
// ----------------------------------------------------------------------------
// qe_cordic_cell
// one vectoring micro-rotation of the cordic arctangent chain
// ----------------------------------------------------------------------------
module qe_cordic_cell import qe_pkg::*; #(
	parameter int CW    = 34,
	parameter int STAGE = 0
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [CW-1:0]    x_in,
	input  logic signed [CW-1:0]    y_in,
	input  logic signed [ANG_W-1:0] ang_in,
	input  logic                    zero_in,
	output logic signed [CW-1:0]    x_q,
	output logic signed [CW-1:0]    y_q,
	output logic signed [ANG_W-1:0] ang_q,
	output logic                    zero_q
);

	logic signed [CW-1:0] dx, dy;

	assign dx = x_in >>> STAGE;
	assign dy = y_in >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= zero_in;
			if (!y_in[CW-1]) begin
				x_q   <= x_in + dy;
				y_q   <= y_in - dx;
				ang_q <= ang_in + atan_tab(STAGE);
			end else begin
				x_q   <= x_in - dy;
				y_q   <= y_in + dx;
				ang_q <= ang_in - atan_tab(STAGE);
			end
		end
	end

endmodule

// File: sv/qe_cordic_lane.sv
// ----------------------------------------------------------------------------
// qe_cordic_lane
// quadrant fold, cordic cell chain, rounding to the output angle scale and clamping to the limit
// ----------------------------------------------------------------------------
module qe_cordic_lane import qe_pkg::*; #(
	parameter int CW      = 34,
	parameter int STAGES  = 16,
	parameter int FRAC    = 6,
	parameter int OUT_W   = 15,
	parameter int LIM_DEG = 180
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] x_in,
	output logic [OUT_W-1:0]     angle_q
);

	localparam int OUT_SHIFT = ANG_SHIFT - FRAC;
	localparam logic signed [ANG_W-1:0] HALF = ANG_W'(1) <<< (OUT_SHIFT - 1);
	localparam logic signed [ANG_W-1:0] LIM  = ANG_W'(LIM_DEG) <<< FRAC;

	logic signed [CW-1:0]    x_c   [STAGES+1];
	logic signed [CW-1:0]    y_c   [STAGES+1];
	logic signed [ANG_W-1:0] ang_c [STAGES+1];
	logic                    zero_c [STAGES+1];
	logic signed [ANG_W-1:0] r;

	// fold the left half plane onto the right one
	always_ff @(posedge clk) begin
		if (en) begin
			zero_c[0] <= (x_in == '0) && (y_in == '0);
			if (x_in[CW-1] && !y_in[CW-1]) begin
				x_c[0]   <= y_in;
				y_c[0]   <= -x_in;
				ang_c[0] <= DEG90;
			end else if (x_in[CW-1]) begin
				x_c[0]   <= -y_in;
				y_c[0]   <= x_in;
				ang_c[0] <= -DEG90;
			end else begin
				x_c[0]   <= x_in;
				y_c[0]   <= y_in;
				ang_c[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		qe_cordic_cell #(.CW(CW), .STAGE(i)) u_cell (
			.clk    (clk),
			.en     (en),
			.x_in   (x_c[i]),
			.y_in   (y_c[i]),
			.ang_in (ang_c[i]),
			.zero_in(zero_c[i]),
			.x_q    (x_c[i+1]),
			.y_q    (y_c[i+1]),
			.ang_q  (ang_c[i+1]),
			.zero_q (zero_c[i+1])
		);
	end

	// only the angle of the last cell is used
	assign r = zero_c[STAGES] ? ANG_W'(0) : (ang_c[STAGES] + HALF) >>> OUT_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (r > LIM)
				angle_q <= OUT_W'(LIM);
			else if (r < -LIM)
				angle_q <= OUT_W'(-LIM);
			else
				angle_q <= OUT_W'(r);
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks quaternion_to_euler_angles against a bit-exact angle predictor
// ----------------------------------------------------------------------------
// a short table of fixed quaternions runs first: identity, zero, the axis
// flips, the range extremes and the clamped pitch term. a long random stream
// follows it. the sender works in bursts and the receiver stalls on its own
// pattern. every result is compared field by field with a queue of angles.
// ----------------------------------------------------------------------------
module tb_top;
	import qe_pkg::*;

	localparam int N_RAND    = 1330;
	localparam int MAX_CYC   = 400000;
	localparam int LAT       = 52;
	localparam longint DEG90_L  = longint'(90) <<< ANG_SHIFT;
	localparam longint DEG180_L = longint'(180) <<< ANG_SHIFT;
	localparam int OSH       = ANG_SHIFT - 6;

	typedef struct packed {
		logic signed [YAW_W-1:0]   yaw;
		logic signed [PITCH_W-1:0] pitch;
		logic signed [ROLL_W-1:0]  roll;
	} euler_t;

	typedef struct {
		logic signed [15:0] w, x, y, z;
		bit                 typed;
		euler_t             ang;
	} quat_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	// quat_w, quat_x, quat_y, quat_z
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	// roll_angle, pitch_angle, yaw_angle
	logic [OUT_TDATA_W-1:0] m_tdata;

	euler_t angle_q[$];
	int     n_bad = 0;
	int     n_res = 0;
	int     cyc = 0;
	bit     sent_all = 0;

	quaternion_to_euler_angles dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic longint vec_atan2(input longint yy, input longint xx);
		longint a, t, dx, dy;
		a = 0;
		if (xx == 0 && yy == 0)
			return 0;
		if (xx < 0) begin
			if (yy >= 0) begin
				t = xx; xx = yy; yy = -t; a = DEG90_L;
			end else begin
				t = xx; xx = -yy; yy = t; a = -DEG90_L;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = xx >>> i;
			dy = yy >>> i;
			if (yy >= 0) begin
				xx += dy; yy -= dx; a += longint'(atan_tab(i));
			end else begin
				xx -= dy; yy += dx; a -= longint'(atan_tab(i));
			end
		end
		return a;
	endfunction

	function automatic longint deg64(input longint a, input longint lim_int);
		longint r, lim;
		r = (a + (longint'(1) <<< (OSH - 1))) >>> OSH;
		lim = lim_int >>> OSH;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic euler_t quat_to_euler(input logic signed [15:0] qw, qx, qy, qz);
		longint w, x, y, z, one, t0, t1, t2, t3, t4, p, c;
		euler_t e;
		w = qw; x = qx; y = qy; z = qz;
		one = longint'(1) <<< 28;
		t0 = 2 * (w * x + y * z);
		t1 = one - 2 * (x * x + y * y);
		t2 = 2 * (w * y - z * x);
		t3 = 2 * (w * z + x * y);
		t4 = one - 2 * (y * y + z * z);
		if (t2 > one) t2 = one;
		if (t2 < -one) t2 = -one;
		p = t2 * 4;
		c = longint'(int_sqrt((64'd1 << 60) - longint'(p * p)));
		e.roll  = ROLL_W'(deg64(vec_atan2(t0, t1), DEG180_L));
		e.pitch = PITCH_W'(deg64(vec_atan2(p, c), DEG90_L));
		e.yaw   = YAW_W'(deg64(vec_atan2(t3, t4), DEG180_L));
		return e;
	endfunction

	function automatic logic signed [15:0] rand_q();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	task automatic send_quat(input quat_row_t r);
		s_tdata  <= {r.z, r.y, r.x, r.w};
		s_tvalid <= 1;
		do
			@(posedge clk);
		while (!s_tready);
		angle_q.push_back(r.typed ? r.ang : quat_to_euler(r.w, r.x, r.y, r.z));
		@(negedge clk);
		if ($urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// directed rows: w, x, y, z, typed expectation, roll, pitch, yaw
	quat_row_t dir_tab[] = '{
		'{16384, 0, 0, 0, 1, '{yaw: 0, pitch: 0, roll: 0}},
		'{0, 0, 0, 0, 1, '{yaw: 0, pitch: 0, roll: 0}},
		'{0, 16384, 0, 0, 1, '{yaw: 0, pitch: 0, roll: 11520}},
		'{-16384, 0, 0, 0, 1, '{yaw: 0, pitch: 0, roll: 0}},
		'{0, -16384, 0, 0, 1, '{yaw: 0, pitch: 0, roll: 11520}},
		'{0, 0, 0, 16384, 1, '{yaw: 11520, pitch: 0, roll: 0}},
		'{0, 0, 16384, 0, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{16384, 0, 16384, 0, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{16384, 0, -16384, 0, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{11585, 0, 11585, 0, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{11585, 11585, 0, 0, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{11585, 0, 0, -11585, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{16384, 16384, 16384, 16384, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{-16384, -16384, -16384, -16384, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{16384, -16384, 16384, -16384, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{-16384, 16384, -16384, 16384, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{8192, 8192, 8192, 8192, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{1, -1, 1, -1, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{0, 0, 1, 1, 0, '{yaw: 0, pitch: 0, roll: 0}},
		'{0, -16384, 0, 1, 0, '{yaw: 0, pitch: 0, roll: 0}}
	};

	initial begin
		quat_row_t r;
		repeat (4) @(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);
		foreach (dir_tab[i])
			send_quat(dir_tab[i]);
		for (int n = 0; n < N_RAND; n++) begin
			if (n == N_RAND / 2) begin
				s_tvalid <= 0;
				wait (angle_q.size() == 0);
				@(negedge clk);
			end
			r.w = rand_q(); r.x = rand_q(); r.y = rand_q(); r.z = rand_q();
			r.typed = 0;
			send_quat(r);
		end
		s_tvalid <= 0;
		sent_all = 1;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 0;
		else if (cyc[9:7] == 3'd5)
			m_tready <= 1;
		else
			m_tready <= (cyc % 11 < 7) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 2) == 0);
	end

	always @(posedge clk) begin
		euler_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[ROLL_W+PITCH_W+YAW_W-1:0];
			n_res++;
			if (angle_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result %h", m_tdata);
			end else begin
				want = angle_q.pop_front();
				if (got !== want || m_tdata[OUT_TDATA_W-1:ROLL_W+PITCH_W+YAW_W] !== '0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("result %0d: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d",
							n_res, want.roll, got.roll, want.pitch, got.pitch,
							want.yaw, got.yaw);
				end
			end
		end
	end

	initial begin
		wait (sent_all && angle_q.size() == 0);
		repeat (2 * LAT) @(posedge clk);
		$display("covered %0d quaternions: axis flips, extremes, clamped pitch, random",
			N_RAND + dir_tab.size());
		$display("%0d results compared, %0d mismatches", n_res, n_bad);
		if (n_bad == 0 && angle_q.size() == 0 && !m_tvalid)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > MAX_CYC) begin
			$display("timeout");
			$display("tb_top NOT OK");
			$finish;
		end
	end

endmodule
